@@ sv/ccp_pkg.sv @@
// Package for the cycling speed and cadence parser.
// Holds the transfer structs, packet layout codes and time extension helper.
// No dependencies.
`timescale 1ns / 1ps

package ccp_pkg;

  // Width of the extended event time accumulator (17 to 64).
  localparam int TIME_EXT_BITS = 40;
  localparam int EVT_TIME_W    = 16;
  // Rollover count: the accumulator's low 16 bits always stay zero.
  localparam int ROLL_W        = TIME_EXT_BITS - EVT_TIME_W;
  localparam int OUT_TIME_W    = 40;

  // Bytes after the flags byte, per part.
  localparam logic [3:0] WHEEL_TAIL = 4'd6;
  localparam logic [3:0] CRANK_TAIL = 4'd4;

  // Byte positions inside the wheel part.
  localparam logic [3:0] WHEEL_TIME_LO_POS = 4'd4;
  localparam logic [3:0] WHEEL_TIME_HI_POS = 4'd5;

  // Byte positions inside the crank part.
  localparam logic [3:0] CRANK_CNT_LO_POS  = 4'd0;
  localparam logic [3:0] CRANK_CNT_HI_POS  = 4'd1;
  localparam logic [3:0] CRANK_TIME_LO_POS = 4'd2;
  localparam logic [3:0] CRANK_TIME_HI_POS = 4'd3;

  localparam int FLAG_WHEEL = 0;
  localparam int FLAG_CRANK = 1;

  typedef struct packed {
    logic       fresh_history;
    logic       first_byte;
    logic [7:0] byte_value;
  } in_item_t;

  typedef struct packed {
    logic                  wheel_present;
    logic                  crank_present;
    logic [31:0]           wheel_revolutions;
    logic [15:0]           crank_revolutions;
    logic [OUT_TIME_W-1:0] wheel_time_ticks;
    logic [OUT_TIME_W-1:0] crank_time_ticks;
  } result_t;

  // Rollover count above the last event time, reduced to the output width.
  function automatic logic [OUT_TIME_W-1:0] ext_time(input logic [ROLL_W-1:0] roll,
                                                     input logic [EVT_TIME_W-1:0] last);
    logic [63:0] wide;
    wide = 64'({roll, last});
    return wide[OUT_TIME_W-1:0];
  endfunction

endpackage

@@ sv/ccp_in_stage.sv @@
// Input register of the cycling speed and cadence parser.
// Holds one accepted byte until the parse stage consumes it. Uses ccp_pkg.
`timescale 1ns / 1ps

module ccp_in_stage (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  ccp_pkg::in_item_t s_item,
  input  logic              advance,
  output logic              item_valid,
  output ccp_pkg::in_item_t item
);
  import ccp_pkg::*;

  logic accept;

  assign s_axis_tready = !item_valid || advance;
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (accept) begin
      item_valid <= 1'b1;
    end else if (advance) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item <= s_item;
    end
  end

endmodule

@@ sv/ccp_parse.sv @@
// Packet parser of the cycling speed and cadence block.
// Assembles fields, extends event times and flags packet completion. Uses ccp_pkg.
`timescale 1ns / 1ps

module ccp_parse (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  ccp_pkg::in_item_t item,
  output logic              res_valid,
  output ccp_pkg::result_t  res
);
  import ccp_pkg::*;

  logic [3:0]            pos, pos_next;
  logic                  active, active_next;
  logic [1:0]            flags, flags_next;
  logic [31:0]           wheel_count, wheel_count_next;
  logic [15:0]           crank_count, crank_count_next;
  logic [7:0]            time_lo, time_lo_next;
  logic [EVT_TIME_W-1:0] wheel_last, wheel_last_next;
  logic [EVT_TIME_W-1:0] crank_last, crank_last_next;
  logic [ROLL_W-1:0]     wheel_roll, wheel_roll_next;
  logic [ROLL_W-1:0]     crank_roll, crank_roll_next;

  logic [3:0]            rel;
  logic [3:0]            tail;
  logic [EVT_TIME_W-1:0] evt_time;

  always_comb begin
    pos_next         = pos;
    active_next      = active;
    flags_next       = flags;
    wheel_count_next = wheel_count;
    crank_count_next = crank_count;
    time_lo_next     = time_lo;
    wheel_last_next  = wheel_last;
    crank_last_next  = crank_last;
    wheel_roll_next  = wheel_roll;
    crank_roll_next  = crank_roll;
    res_valid        = 1'b0;
    rel              = flags[FLAG_WHEEL] ? (pos - WHEEL_TAIL) : pos;
    evt_time         = {item.byte_value, time_lo};
    tail             = 4'd0;

    if (step) begin
      if (item.first_byte) begin
        if (item.fresh_history) begin
          wheel_last_next = '0;
          crank_last_next = '0;
          wheel_roll_next = '0;
          crank_roll_next = '0;
        end
        flags_next  = item.byte_value[1:0];
        pos_next    = 4'd0;
        active_next = 1'b1;
        if (flags_next == 2'b00) begin
          res_valid   = 1'b1;
          active_next = 1'b0;
        end
      end else if (active) begin
        if (flags[FLAG_WHEEL] && (pos < WHEEL_TAIL)) begin
          if (pos < WHEEL_TIME_LO_POS) begin
            wheel_count_next[8*pos[1:0] +: 8] = item.byte_value;
          end else if (pos == WHEEL_TIME_LO_POS) begin
            time_lo_next = item.byte_value;
          end else begin
            // high byte of the wheel event time: commit it
            if (evt_time < wheel_last) begin
              wheel_roll_next = wheel_roll + ROLL_W'(1);
            end
            wheel_last_next = evt_time;
          end
        end else if (flags[FLAG_CRANK]) begin
          case (rel)
            CRANK_CNT_LO_POS:  crank_count_next = {8'd0, item.byte_value};
            CRANK_CNT_HI_POS:  crank_count_next = {item.byte_value, crank_count[7:0]};
            CRANK_TIME_LO_POS: time_lo_next = item.byte_value;
            CRANK_TIME_HI_POS: begin
              if (evt_time < crank_last) begin
                crank_roll_next = crank_roll + ROLL_W'(1);
              end
              crank_last_next = evt_time;
            end
            default: ;
          endcase
        end
        pos_next = pos + 4'd1;
        tail = (flags[FLAG_WHEEL] ? WHEEL_TAIL : 4'd0) +
               (flags[FLAG_CRANK] ? CRANK_TAIL : 4'd0);
        if (pos_next >= tail) begin
          res_valid   = 1'b1;
          active_next = 1'b0;
        end
      end
    end
  end

  always_comb begin
    res.wheel_present     = flags_next[FLAG_WHEEL];
    res.crank_present     = flags_next[FLAG_CRANK];
    res.wheel_revolutions = flags_next[FLAG_WHEEL] ? wheel_count_next : 32'd0;
    res.crank_revolutions = flags_next[FLAG_CRANK] ? crank_count_next : 16'd0;
    res.wheel_time_ticks  = flags_next[FLAG_WHEEL] ?
                            ext_time(wheel_roll_next, wheel_last_next) : '0;
    res.crank_time_ticks  = flags_next[FLAG_CRANK] ?
                            ext_time(crank_roll_next, crank_last_next) : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos         <= 4'd0;
      active      <= 1'b0;
      flags       <= 2'b00;
      wheel_count <= '0;
      crank_count <= '0;
      time_lo     <= '0;
      wheel_last  <= '0;
      crank_last  <= '0;
      wheel_roll  <= '0;
      crank_roll  <= '0;
    end else begin
      pos         <= pos_next;
      active      <= active_next;
      flags       <= flags_next;
      wheel_count <= wheel_count_next;
      crank_count <= crank_count_next;
      time_lo     <= time_lo_next;
      wheel_last  <= wheel_last_next;
      crank_last  <= crank_last_next;
      wheel_roll  <= wheel_roll_next;
      crank_roll  <= crank_roll_next;
    end
  end

endmodule

@@ sv/ccp_out_stage.sv @@
// Result register of the cycling speed and cadence parser.
// Holds one result until the downstream side takes it. Uses ccp_pkg.
`timescale 1ns / 1ps

module ccp_out_stage (
  input  logic             clk,
  input  logic             rst,
  input  logic             advance,
  input  logic             load_valid,
  input  ccp_pkg::result_t res,
  output logic             m_axis_tvalid,
  output logic [127:0]     m_axis_tdata,
  output logic [1:0]       m_axis_tuser
);
  import ccp_pkg::*;

  result_t held;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (advance) begin
      m_axis_tvalid <= load_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && load_valid) begin
      held <= res;
    end
  end

  assign m_axis_tdata = {held.crank_time_ticks, held.wheel_time_ticks,
                         held.crank_revolutions, held.wheel_revolutions};
  assign m_axis_tuser = {held.crank_present, held.wheel_present};

endmodule

@@ sv/cycling_speed_cadence_parser.sv @@
// Top level of the cycling speed and cadence measurement parser.
// Instantiates ccp_in_stage, ccp_parse and ccp_out_stage; uses ccp_pkg.
//
//   channel  dir  width            contents
//   s_axis   in   tdata 8, user 2  one packet byte, start and fresh-history marks
//   m_axis   out  tdata 128,user 2 counts and extended event times per packet
//
// One byte per cycle while the result register is not stalled: a byte is held
// in the input register, parsed by the field and time-extension logic, and lands
// in the result register. A packet's result is registered from its last byte.
// Reset (rst, synchronous) clears the history, the packet state and both
// valid flags. A stalled result holds the parse stage; one more byte is
// still taken into the input register meanwhile.
`timescale 1ns / 1ps

module cycling_speed_cadence_parser (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,   // [7:0] byte_value
  input  logic [1:0]   s_axis_tuser,   // [0] first_byte, [1] fresh_history
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [127:0] m_axis_tdata,   // [31:0] wheel_revolutions,
                                       // [47:32] crank_revolutions,
                                       // [87:48] wheel_time_ticks,
                                       // [127:88] crank_time_ticks
  output logic [1:0]   m_axis_tuser    // [0] wheel_present, [1] crank_present
);
  import ccp_pkg::*;

  in_item_t s_item;
  in_item_t item;
  logic     item_valid;
  logic     advance;
  logic     step;
  logic     res_valid;
  result_t  res;

  // Advance the pipe whenever the result register is free or being drained.
  assign advance = !m_axis_tvalid || m_axis_tready;
  assign step    = item_valid && advance;

  assign s_item.byte_value    = s_axis_tdata;
  assign s_item.first_byte    = s_axis_tuser[0];
  assign s_item.fresh_history = s_axis_tuser[1];

  ccp_in_stage u_in (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_item        (s_item),
    .advance       (advance),
    .item_valid    (item_valid),
    .item          (item)
  );

  // Parse the held byte; a result is flagged on the packet's last byte.
  ccp_parse u_parse (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .item      (item),
    .res_valid (res_valid),
    .res       (res)
  );

  // Hold the finished result until downstream takes the transfer.
  ccp_out_stage u_out (
    .clk           (clk),
    .rst           (rst),
    .advance       (advance),
    .load_valid    (step && res_valid),
    .res           (res),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule

@@ verif/tb.sv @@
// Self-checking bench for cycling_speed_cadence_parser: streams measurement packets
// in, predicts each packet's counts and extended event times, checks the results.
// Depends on ccp_pkg and the parser RTL only.
`timescale 1ns / 1ps

module tb;
  import ccp_pkg::*;

  localparam int STALL_LIMIT = 2000;     // cycles with no transfer before giving up
  localparam int LONG_HOLD = 400;        // one long receiver hold-off
  localparam int SETTLE_CYCLES = 8;      // wait after draining, before the verdict
  localparam int MAX_REPORTS = 10;
  localparam logic [TIME_EXT_BITS-1:0] ROLL_STEP = TIME_EXT_BITS'(65536);

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [7:0]   s_axis_tdata = '0;      // [7:0] byte_value
  logic [1:0]   s_axis_tuser = '0;      // [0] first_byte, [1] fresh_history
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [127:0] m_axis_tdata;           // [31:0] wheel revs, [47:32] crank revs,
                                        // [87:48] wheel ticks, [127:88] crank ticks
  logic [1:0]   m_axis_tuser;           // [0] wheel_present, [1] crank_present

  cycling_speed_cadence_parser u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Bytes waiting to be offered, and packet results still owed by the block.
  in_item_t byte_backlog[$];
  result_t  expected_readings[$];

  int send_idle_pct = 0;
  int take_idle_pct = 0;
  int bytes_queued = 0;
  int bytes_accepted = 0;
  int mismatches = 0;
  int quiet_cycles = 0;
  bit byte_taken = 1'b0;
  bit hold_request = 1'b0;
  bit hold_done = 1'b0;
  int hold_left = 0;

  // Parser state as predicted from the accepted bytes.
  logic [3:0]               pkt_pos = '0;
  logic                     pkt_active = 1'b0;
  logic [1:0]               pkt_flags = '0;
  logic [31:0]              w_count = '0;
  logic [15:0]              c_count = '0;
  logic [7:0]               time_lo = '0;
  logic [15:0]              w_last = '0;
  logic [15:0]              c_last = '0;
  logic [TIME_EXT_BITS-1:0] w_roll = '0;
  logic [TIME_EXT_BITS-1:0] c_roll = '0;

  function automatic logic [3:0] tail_bytes(input logic [1:0] flags);
    return (flags[FLAG_WHEEL] ? WHEEL_TAIL : 4'd0) + (flags[FLAG_CRANK] ? CRANK_TAIL : 4'd0);
  endfunction

  // Rollover sum plus last event time, wrapped at the accumulator width.
  function automatic logic [OUT_TIME_W-1:0] event_ticks(input logic [TIME_EXT_BITS-1:0] roll,
                                                        input logic [15:0] last_t);
    logic [TIME_EXT_BITS-1:0] sum;
    sum = roll + TIME_EXT_BITS'(last_t);
    return OUT_TIME_W'(sum);
  endfunction

  task automatic close_packet();
    result_t r;
    r = '0;
    pkt_active = 1'b0;
    if (pkt_flags[FLAG_WHEEL]) begin
      r.wheel_present = 1'b1;
      r.wheel_revolutions = w_count;
      r.wheel_time_ticks = event_ticks(w_roll, w_last);
    end
    if (pkt_flags[FLAG_CRANK]) begin
      r.crank_present = 1'b1;
      r.crank_revolutions = c_count;
      r.crank_time_ticks = event_ticks(c_roll, c_last);
    end
    expected_readings.push_back(r);
  endtask

  task automatic parse_measurement_byte(input in_item_t it);
    logic [3:0]  rel;
    logic [15:0] t;
    if (it.first_byte) begin
      if (it.fresh_history) begin
        w_last = '0;
        c_last = '0;
        w_roll = '0;
        c_roll = '0;
      end
      pkt_flags = it.byte_value[1:0];
      pkt_pos = '0;
      pkt_active = 1'b1;
      if (tail_bytes(pkt_flags) == 4'd0) close_packet();
      return;
    end
    // Stray bytes outside a packet are dropped.
    if (!pkt_active) return;
    rel = pkt_pos;
    if (pkt_flags[FLAG_WHEEL] && rel < WHEEL_TAIL) begin
      if (rel < WHEEL_TIME_LO_POS) begin
        w_count[8*rel +: 8] = it.byte_value;
      end else if (rel == WHEEL_TIME_LO_POS) begin
        time_lo = it.byte_value;
      end else begin
        t = {it.byte_value, time_lo};
        if (t < w_last) w_roll = w_roll + ROLL_STEP;
        w_last = t;
      end
    end else if (pkt_flags[FLAG_CRANK]) begin
      if (pkt_flags[FLAG_WHEEL]) rel = rel - WHEEL_TAIL;
      case (rel)
        CRANK_CNT_LO_POS: c_count = {8'd0, it.byte_value};
        CRANK_CNT_HI_POS: c_count[15:8] = it.byte_value;
        CRANK_TIME_LO_POS: time_lo = it.byte_value;
        CRANK_TIME_HI_POS: begin
          t = {it.byte_value, time_lo};
          if (t < c_last) c_roll = c_roll + ROLL_STEP;
          c_last = t;
        end
        default: ;
      endcase
    end
    pkt_pos = pkt_pos + 4'd1;
    if (pkt_pos >= tail_bytes(pkt_flags)) close_packet();
  endtask

  task automatic flag_mismatch(input string what, input result_t want, input result_t got);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display({"%0t %s: expected w=%b c=%b wrev=%h crev=%h wt=%h ct=%h, ",
                "got w=%b c=%b wrev=%h crev=%h wt=%h ct=%h"},
               $realtime, what, want.wheel_present, want.crank_present, want.wheel_revolutions,
               want.crank_revolutions, want.wheel_time_ticks, want.crank_time_ticks,
               got.wheel_present, got.crank_present, got.wheel_revolutions,
               got.crank_revolutions, got.wheel_time_ticks, got.crank_time_ticks);
  endtask

  // Sender: advance to the next byte once the current one is transferred.
  always @(negedge clk) begin : drive_bytes
    in_item_t nxt;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || byte_taken) begin
      if (byte_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        nxt = byte_backlog.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= nxt.byte_value;
        s_axis_tuser <= {nxt.fresh_history, nxt.first_byte};
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: random back-pressure, plus one long hold-off on request.
  always @(negedge clk) begin : drive_ready
    if (hold_request && !hold_done) begin
      hold_left = LONG_HOLD;
      hold_done = 1'b1;
    end
    if (hold_left > 0) begin
      m_axis_tready <= 1'b0;
      hold_left--;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= take_idle_pct);
    end
  end

  // Monitor: check results first, then predict from the accepted byte.
  always @(posedge clk) begin : watch_ports
    result_t  got;
    result_t  want;
    in_item_t it;
    bit       result_taken;
    if (rst) begin
      byte_taken = 1'b0;
      quiet_cycles = 0;
    end else begin
      byte_taken = s_axis_tvalid && s_axis_tready;
      result_taken = m_axis_tvalid && m_axis_tready;
      if (result_taken) begin
        got.wheel_present = m_axis_tuser[0];
        got.crank_present = m_axis_tuser[1];
        got.wheel_revolutions = m_axis_tdata[31:0];
        got.crank_revolutions = m_axis_tdata[47:32];
        got.wheel_time_ticks = m_axis_tdata[87:48];
        got.crank_time_ticks = m_axis_tdata[127:88];
        if (expected_readings.size() == 0) begin
          flag_mismatch("unexpected result", '0, got);
        end else begin
          want = expected_readings.pop_front();
          if (got.wheel_present !== want.wheel_present ||
              got.crank_present !== want.crank_present ||
              got.wheel_revolutions !== want.wheel_revolutions ||
              got.crank_revolutions !== want.crank_revolutions ||
              got.wheel_time_ticks !== want.wheel_time_ticks ||
              got.crank_time_ticks !== want.crank_time_ticks)
            flag_mismatch("result mismatch", want, got);
        end
      end
      if (byte_taken) begin
        it.byte_value = s_axis_tdata;
        it.first_byte = s_axis_tuser[0];
        it.fresh_history = s_axis_tuser[1];
        parse_measurement_byte(it);
        bytes_accepted++;
      end
      if (byte_taken || result_taken) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  task automatic queue_byte(input logic [7:0] b, input logic first, input logic fresh);
    in_item_t it;
    it.byte_value = b;
    it.first_byte = first;
    it.fresh_history = fresh;
    byte_backlog.push_back(it);
    bytes_queued++;
  endtask

  // Flags byte, then up to body_len body bytes; a short body leaves the packet open.
  task automatic queue_packet(input logic [7:0] flags, input logic fresh, input logic [31:0] wc,
                              input logic [15:0] wt, input logic [15:0] cc,
                              input logic [15:0] ct, input int body_len, output int sent);
    logic [7:0] body[$];
    if (flags[FLAG_WHEEL]) begin
      for (int i = 0; i < 4; i++) body.push_back(wc[8*i +: 8]);
      body.push_back(wt[7:0]);
      body.push_back(wt[15:8]);
    end
    if (flags[FLAG_CRANK]) begin
      body.push_back(cc[7:0]);
      body.push_back(cc[15:8]);
      body.push_back(ct[7:0]);
      body.push_back(ct[15:8]);
    end
    if (body_len > body.size()) body_len = body.size();
    queue_byte(flags, 1'b1, fresh);
    for (int i = 0; i < body_len; i++) queue_byte(body[i], 1'b0, 1'($urandom_range(1)));
    sent = body_len + 1;
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      default: return $urandom;
    endcase
  endfunction

  // Mostly complete packets; some cut short, some stray bytes with no flags mark.
  task automatic queue_random_packet(inout int budget);
    int pick;
    int sent;
    int body_len;
    pick = $urandom_range(99);
    if (pick < 8) begin
      queue_byte(8'($urandom_range(255)), 1'b0, 1'($urandom_range(1)));
      budget -= 1;
      return;
    end
    body_len = (pick < 18) ? $urandom_range(9) : 16;
    queue_packet(8'($urandom_range(255)), $urandom_range(19) == 0, pick_value(), pick_value(),
                 pick_value(), pick_value(), body_len, sent);
    budget -= sent;
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (bytes_accepted != bytes_queued || expected_readings.size() != 0);
  endtask

  initial begin
    int budget;
    int sent;
    repeat (5) @(negedge clk);
    rst = 1'b0;

    send_idle_pct = 38;
    take_idle_pct = 50;
    // Neither part, with the upper flag bits set: result straight from the flags byte.
    queue_packet(8'hFC, 1'b1, '0, '0, '0, '0, 0, sent);
    // Byte outside any packet, carrying a fresh mark without a flags byte.
    queue_byte(8'hA5, 1'b0, 1'b1);
    // Both parts at their maximum values.
    queue_packet(8'hFF, 1'b1, '1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16, sent);
    // Crank packet aborted after its count by the next flags byte.
    queue_packet(8'h02, 1'b0, '0, '0, 16'h1234, 16'h0001, 2, sent);
    // Wheel and crank times drop to zero: one rollover each.
    queue_packet(8'h01, 1'b0, '0, 16'h0000, '0, '0, 16, sent);
    queue_packet(8'h02, 1'b0, '0, '0, 16'h0000, 16'h0000, 16, sent);

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 38;
          take_idle_pct = 50;
        end
        1: begin
          send_idle_pct = 50;
          take_idle_pct = 38;
        end
        default: begin
          send_idle_pct = 0;
          take_idle_pct = 0;
          // Hold the output off while bytes keep coming so the input backs up.
          hold_request = 1'b1;
        end
      endcase
      budget = 250;
      while (budget > 0) queue_random_packet(budget);
      // Wait until every queued byte is accepted and every owed result transferred.
      wait_drained();
    end

    repeat (SETTLE_CYCLES) @(negedge clk);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
